@@ hw/rtl/hrps_pkg.sv @@
// ----------------------------------------------------------------------------
// hrps_pkg
// Shared types, codes and constants of the hopping rc packet sequencer.
// ----------------------------------------------------------------------------
package hrps_pkg;

	localparam int HOP_CHANNELS = 30;
	localparam int PKT_BYTES    = 13;

	// result action codes
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_CAL  = 2'd1;
	localparam logic [1:0] ACT_FAST = 2'd2;
	localparam logic [1:0] ACT_BYTE = 2'd3;

	// register indexes
	localparam logic REG_TX_ID    = 1'b0;
	localparam logic REG_HOP_CODE = 1'b1;

	// delays in half microseconds
	localparam logic [15:0] DLY_SLOT  = 16'd4000;
	localparam logic [15:0] DLY_DATA1 = 16'd3260;
	localparam logic [15:0] DLY_DATA2 = 16'd4040;

	localparam logic [7:0]  PKT_HEADER = 8'h81;
	localparam logic [11:0] CH_CENTER  = 12'd1520;
	localparam logic [11:0] CH_MAX     = 12'd2135;
	localparam logic [11:0] CH_MIN     = 12'd905;
	// ceil(2^30 / 1000): exact floor(m / 1000) for m below 2^21
	localparam logic [20:0] RECIP_1000 = 21'd1073742;
	localparam int          RECIP_SHIFT = 30;

	typedef enum logic [4:0] {
		PH_START = 5'b00001,
		PH_CAL   = 5'b00010,
		PH_DATA1 = 5'b00100,
		PH_DATA2 = 5'b01000,
		PH_TUNE  = 5'b10000
	} phase_t;

endpackage

@@ hw/rtl/hopping_rc_packet_sequencer.sv @@
// ----------------------------------------------------------------------------
// hopping_rc_packet_sequencer
// Tick-driven five-phase sequencer of a frequency hopping rc transmitter:
// calibration of all hop channels, two data packets per hop, fast retune.
// ----------------------------------------------------------------------------
// Each accepted item is one scheduler tick. It is registered at the input
// (channel magnitudes times 41 are formed there), then the phase logic and
// the four channel scalers fill a 13-byte output shift buffer. Start,
// calibrate and retune ticks give one result, data ticks give 13 packet
// bytes, one per cycle unless the receiver stalls. While the buffer drains,
// one further tick waits in the input register and the input stalls until
// the last byte of the buffer leaves. The sustained rate is one result per
// cycle while the receiver does not stall, set by the output buffer that
// hands out one byte a cycle.
module hopping_rc_packet_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] chan_0,
	input  logic signed [15:0] chan_1,
	input  logic signed [15:0] chan_2,
	input  logic signed [15:0] chan_3,
	input  logic signed [15:0] chan_4,
	input  logic signed [15:0] chan_5,
	input  logic signed [15:0] chan_6,
	input  logic signed [15:0] chan_7,
	input  logic [7:0]         cal_read,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         action,
	output logic [7:0]         byte_value,
	output logic [7:0]         cal_value,
	output logic [15:0]        delay_half_us,
	output logic               last
);

	logic [15:0] tx_id_q;
	logic [4:0]  hop_code_q;

	hrps_pkg::phase_t phase_q, phase_nxt;
	logic [4:0]  hop_q, hop_nxt;
	logic [9:0]  fc_q, fc_nxt;
	logic [7:0]  cal_tab_q [hrps_pkg::HOP_CHANNELS];

	logic        s1_valid_q;
	logic [20:0] mag41_s1 [8];
	logic [7:0]  neg_s1;
	logic [7:0]  cal_s1;

	logic [7:0]  buf_q [hrps_pkg::PKT_BYTES];
	logic [3:0]  rem_q;
	logic [1:0]  act_q;
	logic [7:0]  calv_q;
	logic [15:0] dly_q;

	logic        in_take, emit, buf_free, load;

	logic [7:0]  ld_buf [hrps_pkg::PKT_BYTES];
	logic [3:0]  ld_rem;
	logic [1:0]  ld_act;
	logic [7:0]  ld_cal;
	logic [15:0] ld_dly;
	logic        cal_wr;

	logic signed [15:0] chan_in [8];
	logic [15:0] mag_in [8];

	logic        second, odd;
	logic [20:0] m_sel [4];
	logic [41:0] prod [4];
	logic [11:0] quo [4];
	logic [11:0] raw_ch [4];
	logic [11:0] ch [4];
	logic [5:0]  cmd;
	logic [6:0]  step, hsum;
	logic [4:0]  hop_hopped, hop_inc;
	logic [7:0]  reg_cur, reg_inc;

	// handshake
	assign emit      = out_valid && !out_stall;
	assign buf_free  = (rem_q == 4'd0) || ((rem_q == 4'd1) && !out_stall);
	assign load      = s1_valid_q && buf_free;
	assign in_stall  = s1_valid_q && !load;
	assign in_take   = in_valid && !in_stall;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_id_q    <= '0;
			hop_code_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hrps_pkg::REG_TX_ID:    tx_id_q    <= cfg_data;
				hrps_pkg::REG_HOP_CODE: hop_code_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// input stage
	assign chan_in[0] = chan_0;
	assign chan_in[1] = chan_1;
	assign chan_in[2] = chan_2;
	assign chan_in[3] = chan_3;
	assign chan_in[4] = chan_4;
	assign chan_in[5] = chan_5;
	assign chan_in[6] = chan_6;
	assign chan_in[7] = chan_7;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mag_in[i] = chan_in[i][15] ? (16'd0 - 16'(chan_in[i])) : 16'(chan_in[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (load) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			for (int i = 0; i < 8; i++) begin
				mag41_s1[i] <= {mag_in[i], 5'd0} + {2'd0, mag_in[i], 3'd0}
					+ {5'd0, mag_in[i]};
				neg_s1[i]   <= chan_in[i][15];
			end
			cal_s1 <= cal_read;
		end
	end

	// channel scaling: 1520 - v*41/1000, clamped
	assign second = (phase_q == hrps_pkg::PH_DATA2);
	assign odd    = fc_q[0] ^ second;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			m_sel[i]  = odd ? mag41_s1[i + 4] : mag41_s1[i];
			prod[i]   = 42'(m_sel[i]) * 42'(hrps_pkg::RECIP_1000);
			quo[i]    = prod[i][hrps_pkg::RECIP_SHIFT +: 12];
			raw_ch[i] = (odd ? neg_s1[i + 4] : neg_s1[i])
				? (hrps_pkg::CH_CENTER + quo[i]) : (hrps_pkg::CH_CENTER - quo[i]);
			if (raw_ch[i] > hrps_pkg::CH_MAX) begin
				ch[i] = hrps_pkg::CH_MAX;
			end else if (raw_ch[i] < hrps_pkg::CH_MIN) begin
				ch[i] = hrps_pkg::CH_MIN;
			end else begin
				ch[i] = raw_ch[i];
			end
		end
	end

	// hop arithmetic
	always_comb begin
		step = {2'd0, hop_code_q} + 7'd2;
		hsum = {2'd0, hop_q} + step;
		if (hsum > 7'd29) begin
			if (hsum < 7'd31) begin
				hsum = hsum + step;
			end
			hsum = hsum - 7'd31;
		end
		hop_hopped = hsum[4:0];
		hop_inc    = hop_q + 5'd1;
		reg_cur    = {3'd0, hop_q} * 8'd6 + 8'd16;
		reg_inc    = {3'd0, hop_inc} * 8'd6 + 8'd16;
	end

	assign cmd = {2'd0, odd, 1'b0, 1'b1, second};

	// phase logic
	always_comb begin
		phase_nxt = phase_q;
		hop_nxt   = hop_q;
		fc_nxt    = fc_q;
		cal_wr    = 1'b0;
		for (int i = 0; i < hrps_pkg::PKT_BYTES; i++) begin
			ld_buf[i] = 8'd0;
		end
		ld_rem = 4'd1;
		ld_act = hrps_pkg::ACT_NONE;
		ld_cal = 8'd0;
		ld_dly = hrps_pkg::DLY_SLOT;
		unique case (phase_q)
			hrps_pkg::PH_START: begin
				hop_nxt   = 5'd0;
				ld_act    = hrps_pkg::ACT_CAL;
				ld_buf[0] = 8'd16;
				phase_nxt = hrps_pkg::PH_CAL;
			end
			hrps_pkg::PH_CAL: begin
				cal_wr = (hop_q < 5'(hrps_pkg::HOP_CHANNELS));
				if (hop_inc < 5'(hrps_pkg::HOP_CHANNELS)) begin
					hop_nxt   = hop_inc;
					ld_act    = hrps_pkg::ACT_CAL;
					ld_buf[0] = reg_inc;
				end else begin
					hop_nxt   = 5'd0;
					fc_nxt    = 10'd0;
					phase_nxt = hrps_pkg::PH_DATA1;
				end
			end
			hrps_pkg::PH_DATA1, hrps_pkg::PH_DATA2: begin
				fc_nxt     = fc_q + {9'd0, second};
				ld_rem     = 4'(hrps_pkg::PKT_BYTES);
				ld_act     = hrps_pkg::ACT_BYTE;
				ld_dly     = second ? hrps_pkg::DLY_DATA2 : hrps_pkg::DLY_DATA1;
				ld_buf[0]  = hrps_pkg::PKT_HEADER;
				ld_buf[1]  = tx_id_q[15:8];
				ld_buf[2]  = tx_id_q[7:0];
				ld_buf[5]  = {hop_q, ch[0][11:9]};
				ld_buf[6]  = ch[0][8:1];
				ld_buf[7]  = {ch[0][0], ch[1][11:5]};
				ld_buf[8]  = {ch[1][4:0], ch[2][11:9]};
				ld_buf[9]  = ch[2][8:1];
				ld_buf[10] = {ch[2][0], ch[3][11:5]};
				ld_buf[11] = {ch[3][4:0], hop_code_q[4:2]};
				ld_buf[12] = {hop_code_q[1:0], cmd};
				if (second) begin
					hop_nxt   = hop_hopped;
					phase_nxt = hrps_pkg::PH_TUNE;
				end else begin
					phase_nxt = hrps_pkg::PH_DATA2;
				end
			end
			hrps_pkg::PH_TUNE: begin
				ld_act    = hrps_pkg::ACT_FAST;
				ld_buf[0] = reg_cur;
				ld_cal    = (hop_q < 5'(hrps_pkg::HOP_CHANNELS)) ? cal_tab_q[hop_q] : 8'd0;
				phase_nxt = hrps_pkg::PH_DATA1;
			end
			default: begin
				phase_nxt = hrps_pkg::PH_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrps_pkg::PH_START;
			hop_q   <= '0;
			fc_q    <= '0;
		end else if (load) begin
			phase_q <= phase_nxt;
			hop_q   <= hop_nxt;
			fc_q    <= fc_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load && cal_wr) begin
			cal_tab_q[hop_q] <= cal_s1;
		end
	end

	// output shift buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= ld_rem;
		end else if (emit) begin
			rem_q <= rem_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q  <= ld_buf;
			act_q  <= ld_act;
			calv_q <= ld_cal;
			dly_q  <= ld_dly;
		end else if (emit) begin
			for (int i = 0; i < hrps_pkg::PKT_BYTES - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

	assign out_valid     = (rem_q != 4'd0);
	assign last          = (rem_q == 4'd1);
	assign action        = act_q;
	assign byte_value    = buf_q[0];
	assign cal_value     = calv_q;
	assign delay_half_us = last ? dly_q : 16'd0;

endmodule

@@ hw/rtl/hrps_checker.sv @@
// ----------------------------------------------------------------------------
// hrps_checker
// Port-level checks of the hopping rc packet sequencer result stream.
// ----------------------------------------------------------------------------
module hrps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  action,
	input logic [7:0]  byte_value,
	input logic [7:0]  cal_value,
	input logic [15:0] delay_half_us,
	input logic        last
);

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(byte_value) && $stable(action)
			&& $stable(last))
		else $error("stalled result changed");

	// only packet bytes precede the final result, and they carry no delay
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> action == hrps_pkg::ACT_BYTE && delay_half_us == 16'd0)
		else $error("non-final result is not a packet byte");

	// final result carries one of the slot delays
	a_dly: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> delay_half_us == hrps_pkg::DLY_SLOT
			|| delay_half_us == hrps_pkg::DLY_DATA1 || delay_half_us == hrps_pkg::DLY_DATA2)
		else $error("bad final delay");

	// packet bytes follow without a gap
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside packet");

	// calibration byte only on fast tune
	a_cal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != hrps_pkg::ACT_FAST |-> cal_value == 8'd0)
		else $error("calibration byte outside fast tune");

endmodule

bind hopping_rc_packet_sequencer hrps_checker u_hrps_checker (.*);

@@ verif/hrps_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrps_tb_pkg
// Tick and result types for the sequencer bench, and a scoreboard that runs
// its own copy of the phase, hop and calibration state to predict the result
// items of every accepted tick and checks them in order.
// ----------------------------------------------------------------------------
package hrps_tb_pkg;

	import hrps_pkg::*;

	typedef struct packed {
		logic [7:0][15:0] chan;
		logic [7:0]       cal_read;
	} tick_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  byte_value;
		logic [7:0]  cal_value;
		logic [15:0] delay_half_us;
		logic        last;
	} result_t;

	class packet_scoreboard;
		result_t     pending_results [$];
		phase_t      phase;
		logic [4:0]  hop;
		logic [9:0]  frame_cnt;
		logic [7:0]  cal_mem [HOP_CHANNELS];
		logic [15:0] tx_id;
		logic [4:0]  hop_code;
		int          errors;

		function new();
			phase = PH_START;
			hop = 5'd0;
			frame_cnt = 10'd0;
			tx_id = 16'd0;
			hop_code = 5'd0;
			errors = 0;
			foreach (cal_mem[i]) cal_mem[i] = 8'h00;
		endfunction

		function void set_reg(logic index, logic [15:0] data);
			if (index == REG_TX_ID) tx_id = data;
			else hop_code = data[4:0];
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void queue_result(logic [1:0] act, logic [7:0] value, logic [7:0] cal,
				logic [15:0] dly, logic fin);
			result_t r;
			r = {act, value, cal, dly, fin};
			pending_results.push_back(r);
		endfunction

		function logic [7:0] chan_reg();
			int x;
			x = hop * 6 + 16;
			return x[7:0];
		endfunction

		// 1520 - v*410/10000, truncated toward zero, clamped to 905..2135
		function logic [11:0] scale_channel(logic [15:0] raw);
			int v;
			int r;
			v = $signed(raw);
			r = 1520 - (v * 410) / 10000;
			if (r > 2135) r = 2135;
			else if (r < 905) r = 905;
			return r[11:0];
		endfunction

		function void emit_packet(tick_t t, logic second, logic [15:0] dly);
			logic [3:0]  cmd;
			logic [11:0] ch [4];
			logic [7:0]  pk [PKT_BYTES];
			int          base;
			int          i;
			frame_cnt = frame_cnt + second;
			cmd = {frame_cnt[0], 1'b0, 1'b1, second};
			base = frame_cnt[0] ? 4 : 0;
			for (i = 0; i < 4; i++) ch[i] = scale_channel(t.chan[base + i]);
			pk[0] = PKT_HEADER;
			pk[1] = tx_id[15:8];
			pk[2] = tx_id[7:0];
			pk[3] = 8'h00;
			pk[4] = 8'h00;
			pk[5] = {hop, ch[0][11:9]};
			pk[6] = ch[0][8:1];
			pk[7] = {ch[0][0], ch[1][11:5]};
			pk[8] = {ch[1][4:0], ch[2][11:9]};
			pk[9] = ch[2][8:1];
			pk[10] = {ch[2][0], ch[3][11:5]};
			pk[11] = {ch[3][4:0], hop_code[4:2]};
			pk[12] = {hop_code[1:0], 2'b00, cmd};
			for (i = 0; i < PKT_BYTES; i++)
				queue_result(ACT_BYTE, pk[i], 8'h00, (i == PKT_BYTES - 1) ? dly : 16'd0,
					i == PKT_BYTES - 1);
		endfunction

		function void advance_hop();
			int step;
			int h;
			step = hop_code + 2;
			h = hop + step;
			if (h > 29) begin
				if (h < 31) h += step;
				h -= 31;
			end
			hop = h[4:0];
		endfunction

		function void note_tick(tick_t t);
			case (phase)
				PH_START: begin
					hop = 5'd0;
					queue_result(ACT_CAL, chan_reg(), 8'h00, DLY_SLOT, 1'b1);
					phase = PH_CAL;
				end
				PH_CAL: begin
					if (hop < HOP_CHANNELS) cal_mem[hop] = t.cal_read;
					hop = hop + 5'd1;
					if (hop < HOP_CHANNELS) begin
						queue_result(ACT_CAL, chan_reg(), 8'h00, DLY_SLOT, 1'b1);
					end else begin
						hop = 5'd0;
						frame_cnt = 10'd0;
						phase = PH_DATA1;
						queue_result(ACT_NONE, 8'h00, 8'h00, DLY_SLOT, 1'b1);
					end
				end
				PH_DATA1: begin
					emit_packet(t, 1'b0, DLY_DATA1);
					phase = PH_DATA2;
				end
				PH_DATA2: begin
					emit_packet(t, 1'b1, DLY_DATA2);
					advance_hop();
					phase = PH_TUNE;
				end
				PH_TUNE: begin
					queue_result(ACT_FAST, chan_reg(), (hop < HOP_CHANNELS) ? cal_mem[hop] : 8'h00,
						DLY_SLOT, 1'b1);
					phase = PH_DATA1;
				end
				default: begin
					phase = PH_START;
					queue_result(ACT_NONE, 8'h00, 8'h00, DLY_SLOT, 1'b1);
				end
			endcase
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: action %0d byte 0x%02h cal 0x%02h delay %0d last %0d",
						got.action, got.byte_value, got.cal_value, got.delay_half_us, got.last);
				return;
			end
			want = pending_results.pop_front();
			if (got.action !== want.action || got.byte_value !== want.byte_value ||
					got.cal_value !== want.cal_value || got.delay_half_us !== want.delay_half_us ||
					got.last !== want.last) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: expected action %0d byte 0x%02h cal 0x%02h delay %0d last %0d",
						want.action, want.byte_value, want.cal_value, want.delay_half_us, want.last);
					$display("          actual   action %0d byte 0x%02h cal 0x%02h delay %0d last %0d",
						got.action, got.byte_value, got.cal_value, got.delay_half_us, got.last);
				end
			end
		endfunction

		function void close_out();
			if (pending_results.size() != 0) begin
				errors++;
				$display("%0d expected results never arrived", pending_results.size());
			end
		endfunction
	endclass

endpackage

@@ verif/tb_hopping_rc_packet_sequencer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hopping_rc_packet_sequencer
// Drives scheduler ticks through the calibration sweep and many hop cycles
// of data packets and retunes, under several id and hop code settings and
// several patterns of sender gaps and receiver stalls, and checks every
// result item against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_hopping_rc_packet_sequencer;

	import hrps_pkg::*;
	import hrps_tb_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = 1'b0;
	logic [15:0]        cfg_data = 16'd0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] chan_0 = 16'sd0;
	logic signed [15:0] chan_1 = 16'sd0;
	logic signed [15:0] chan_2 = 16'sd0;
	logic signed [15:0] chan_3 = 16'sd0;
	logic signed [15:0] chan_4 = 16'sd0;
	logic signed [15:0] chan_5 = 16'sd0;
	logic signed [15:0] chan_6 = 16'sd0;
	logic signed [15:0] chan_7 = 16'sd0;
	logic [7:0]         cal_read = 8'd0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         action;
	logic [7:0]         byte_value;
	logic [7:0]         cal_value;
	logic [15:0]        delay_half_us;
	logic               last;

	packet_scoreboard sb = new();

	int send_pct = 0;
	int recv_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	hopping_rc_packet_sequencer u_top (.*);

	function bit roll(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function logic [15:0] corner_value(int k);
		case (k % 16)
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return 16'h0001;
			5: return 16'hFFE8;
			6: return 16'hFFE7;
			7: return 16'd24;
			8: return 16'd25;
			9: return 16'hC568;
			10: return 16'hC54F;
			11: return 16'd15000;
			12: return 16'd15025;
			13: return 16'd10000;
			14: return 16'hD8F0;
			default: return 16'h5555;
		endcase
	endfunction

	function tick_t random_tick();
		tick_t t;
		int    v;
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 3))
				0: t.chan[i] = 16'($urandom);
				1: t.chan[i] = 16'($urandom_range(0, 20000) - 10000);
				2: begin
					// around the clamp limits
					v = 14970 + $urandom_range(0, 60);
					if ($urandom_range(0, 1)) v = -v;
					t.chan[i] = v[15:0];
				end
				default: t.chan[i] = corner_value($urandom_range(0, 15));
			endcase
		end
		t.cal_read = 8'($urandom);
		return t;
	endfunction

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall = roll(recv_pct);
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result({action, byte_value, cal_value, delay_half_us, last});
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_hopping_rc_packet_sequencer: errors");
			$finish;
		end
	end

	task automatic write_reg(logic index, logic [15:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(index, data);
	endtask

	task automatic send_tick(tick_t t);
		@(negedge clk);
		while (roll(send_pct)) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		chan_0 = t.chan[0];
		chan_1 = t.chan[1];
		chan_2 = t.chan[2];
		chan_3 = t.chan[3];
		chan_4 = t.chan[4];
		chan_5 = t.chan[5];
		chan_6 = t.chan[6];
		chan_7 = t.chan[7];
		cal_read = t.cal_read;
		do @(posedge clk); while (in_stall);
		sb.note_tick(t);
	endtask

	task automatic stop_and_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic run_phase(logic [15:0] id, logic [4:0] code, int sp, int rp, int hold,
			int count);
		tick_t t;
		write_reg(REG_TX_ID, id);
		write_reg(REG_HOP_CODE, {11'd0, code});
		send_pct = sp;
		recv_pct = rp;
		hold_left = hold;
		repeat (count) begin
			t = random_tick();
			send_tick(t);
		end
		stop_and_drain();
	endtask

	initial begin
		tick_t t;
		int    k;
		int    i;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_TX_ID, 16'hFFFF);
		write_reg(REG_HOP_CODE, 16'd27);
		// start tick and calibration sweep
		for (k = 0; k < HOP_CHANNELS + 1; k++) begin
			t = random_tick();
			if (k == 1) t.cal_read = 8'h00;
			if (k == 2) t.cal_read = 8'hFF;
			send_tick(t);
		end
		// packets with corner channel values
		for (k = 0; k < 12; k++) begin
			for (i = 0; i < 8; i++) t.chan[i] = corner_value(k + i * 5);
			send_tick(t);
		end
		stop_and_drain();

		run_phase(16'h0000, 5'd0, 0, 0, 0, 22);
		run_phase(16'($urandom), 5'd28, 81, 0, 0, 22);
		run_phase(16'($urandom), 5'd30, 0, 81, 0, 77);
		run_phase(16'hFFFF, 5'd31, 29, 29, 0, 22);
		run_phase(16'($urandom), 5'($urandom_range(0, 27)), 0, 0, HOLD_CYCLES, 22);
		run_phase(16'($urandom), 5'd29, 29, 29, 0, 22);

		sb.close_out();
		if (sb.errors == 0) begin
			$display("tb_hopping_rc_packet_sequencer: clean");
		end else begin
			$display("tb_hopping_rc_packet_sequencer: errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/hrps_pkg.sv
hw/rtl/hopping_rc_packet_sequencer.sv
hw/rtl/hrps_checker.sv
verif/hrps_tb_pkg.sv
verif/tb_hopping_rc_packet_sequencer.sv
